/* hw/rtl/itp_pkg.sv */
// Shared types, codes and helpers of the infix to postfix converter.
package itp_pkg;

	localparam int STACK_DEPTH = 32;
	localparam int STACK_AW    = $clog2(STACK_DEPTH);
	localparam int STACK_CW    = $clog2(STACK_DEPTH + 1);
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

	localparam int VALUE_W = 32;
	localparam int OP_W    = 3;
	localparam int KIND_W  = 3;
	localparam int ELEM_W  = 2;
	localparam int S_TDATA_W = 40;
	localparam int M_TDATA_W = 40;

	// Input token kinds.
	localparam logic [KIND_W-1:0] TOK_OPERAND  = 3'd0;
	localparam logic [KIND_W-1:0] TOK_LPAREN   = 3'd1;
	localparam logic [KIND_W-1:0] TOK_RPAREN   = 3'd2;
	localparam logic [KIND_W-1:0] TOK_OPERATOR = 3'd3;
	localparam logic [KIND_W-1:0] TOK_END      = 3'd4;

	// Operator codes; the left paren marker lives only on the stack.
	localparam logic [OP_W-1:0] OP_ADD     = 3'd0;
	localparam logic [OP_W-1:0] OP_SUB     = 3'd1;
	localparam logic [OP_W-1:0] OP_MUL     = 3'd2;
	localparam logic [OP_W-1:0] OP_DIV     = 3'd3;
	localparam logic [OP_W-1:0] OP_POW     = 3'd4;
	localparam logic [OP_W-1:0] CODE_LPAREN = 3'd5;

	// Output element kinds.
	localparam logic [ELEM_W-1:0] ELEM_OPERAND  = 2'd0;
	localparam logic [ELEM_W-1:0] ELEM_OPERATOR = 2'd1;
	localparam logic [ELEM_W-1:0] ELEM_END      = 2'd2;

	typedef enum logic [2:0] {
		CMD_OPERAND,
		CMD_LPAREN,
		CMD_RPAREN,
		CMD_OPERATOR,
		CMD_END
	} itp_cmd_e_t;

	typedef struct packed {
		itp_cmd_e_t           cmd;
		logic [OP_W-1:0]      op;
		logic [VALUE_W-1:0]   value;
	} itp_cmd_t;

	typedef struct packed {
		logic [ELEM_W-1:0]  kind;
		logic [VALUE_W-1:0] value;
		logic [OP_W-1:0]    op;
		logic               err;
		logic               last;
	} itp_result_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RPAREN,
		ST_OPER,
		ST_FLUSH
	} itp_state_t;

	// Binding strength; zero for codes that are not operators.
	function automatic logic [1:0] prec_of(input logic [OP_W-1:0] code);
		logic [1:0] p;
		unique case (code) inside
			OP_ADD, OP_SUB: p = 2'd1;
			OP_MUL, OP_DIV: p = 2'd2;
			OP_POW:         p = 2'd3;
			default:        p = 2'd0;
		endcase
		return p;
	endfunction

endpackage

/* hw/rtl/itp_front.sv */
// Front end: takes token requests, classifies them and hands commands to the queue.
module itp_front import itp_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,
	input  logic [KIND_W-1:0]    s_tuser,
	output logic                 push_valid,
	input  logic                 push_ready,
	output itp_cmd_t             push_data
);

	logic       v_s1;
	itp_cmd_t   cmd_s1;
	itp_cmd_t   cmd_d;
	logic       keep;
	logic [OP_W-1:0]    op_in;
	logic [VALUE_W-1:0] val_in;

	assign op_in  = s_tdata[OP_W-1:0];
	assign val_in = s_tdata[OP_W +: VALUE_W];

	// Tokens with an unknown kind or an unknown operator code are accepted and dropped.
	always_comb begin
		keep        = 1'b1;
		cmd_d.op    = op_in;
		cmd_d.value = val_in;
		cmd_d.cmd   = CMD_OPERAND;
		unique case (s_tuser)
			TOK_OPERAND:  cmd_d.cmd = CMD_OPERAND;
			TOK_LPAREN:   cmd_d.cmd = CMD_LPAREN;
			TOK_RPAREN:   cmd_d.cmd = CMD_RPAREN;
			TOK_OPERATOR: begin
				cmd_d.cmd = CMD_OPERATOR;
				keep      = (op_in <= OP_POW);
			end
			TOK_END:      cmd_d.cmd = CMD_END;
			default:      keep = 1'b0;
		endcase
	end

	assign s_tready   = !v_s1 || push_ready;
	assign push_valid = v_s1;
	assign push_data  = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid && keep;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			cmd_s1 <= cmd_d;
		end
	end

endmodule

/* hw/rtl/itp_queue.sv */
// Short command queue between the front end and the stack engine.
module itp_queue import itp_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push_valid,
	output logic     push_ready,
	input  itp_cmd_t push_data,
	output logic     pop_valid,
	input  logic     pop_ready,
	output itp_cmd_t pop_data
);

	itp_cmd_t              mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0]   wr_ptr_q;
	logic [QUEUE_AW-1:0]   rd_ptr_q;
	logic [QUEUE_CW-1:0]   count_q;
	logic                  do_push;
	logic                  do_pop;

	assign push_ready = (count_q != QUEUE_CW'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

/* hw/rtl/itp_back.sv */
// Stack engine: runs each command against the operator stack and drives the result register.
module itp_back import itp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	output logic        q_ready,
	input  itp_cmd_t    q_data,
	output logic        m_valid,
	input  logic        m_ready,
	output itp_result_t m_res
);

	itp_state_t           state_q, state_d;
	logic [OP_W-1:0]      stk_q [STACK_DEPTH];
	logic [STACK_CW-1:0]  cnt_q, cnt_d;
	logic [STACK_CW-1:0]  lp_q, lp_d;
	logic                 err_q, err_d;
	logic                 hold_v_q, hold_v_d;
	logic [OP_W-1:0]      hold_op_q, hold_op_d;
	logic [OP_W-1:0]      cur_op_q;
	logic [1:0]           cur_prec_q;
	logic                 cur_left_q;
	logic                 cur_load;
	logic                 out_v_q;
	itp_result_t          out_q, out_d;
	logic                 out_load;
	logic                 push_en;
	logic [OP_W-1:0]      push_code;
	logic [STACK_AW-1:0]  top_idx;
	logic [OP_W-1:0]      top;
	logic [1:0]           top_prec;
	logic                 stk_empty, stk_full, top_is_lp, pops, can_out;

	assign top_idx   = STACK_AW'(cnt_q - 1'b1);
	assign top       = stk_q[top_idx];
	assign top_prec  = prec_of(top);
	assign stk_empty = (cnt_q == '0);
	assign stk_full  = (cnt_q == STACK_CW'(STACK_DEPTH));
	assign top_is_lp = (top == CODE_LPAREN);
	assign pops      = !stk_empty && !top_is_lp &&
	                   ((top_prec > cur_prec_q) || ((top_prec == cur_prec_q) && cur_left_q));
	assign can_out   = !out_v_q || m_ready;

	assign m_valid = out_v_q;
	assign m_res   = out_q;

	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		lp_d      = lp_q;
		err_d     = err_q;
		hold_v_d  = hold_v_q;
		hold_op_d = hold_op_q;
		q_ready   = 1'b0;
		cur_load  = 1'b0;
		out_load  = 1'b0;
		out_d     = '0;
		push_en   = 1'b0;
		push_code = CODE_LPAREN;
		unique case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					unique case (q_data.cmd)
						CMD_OPERAND: begin
							if (can_out) begin
								q_ready     = 1'b1;
								out_load    = 1'b1;
								out_d.kind  = ELEM_OPERAND;
								out_d.value = q_data.value;
								out_d.err   = err_q;
								out_d.last  = 1'b1;
							end
						end
						CMD_LPAREN: begin
							q_ready = 1'b1;
							if (stk_full) begin
								err_d = 1'b1;
							end else begin
								push_en = 1'b1;
								cnt_d   = cnt_q + 1'b1;
								lp_d    = lp_q + 1'b1;
							end
						end
						CMD_RPAREN: begin
							// No left paren anywhere on the stack means it cannot match.
							q_ready  = 1'b1;
							hold_v_d = 1'b0;
							if (lp_q == '0) begin
								err_d = 1'b1;
							end
							state_d = ST_RPAREN;
						end
						CMD_OPERATOR: begin
							q_ready  = 1'b1;
							cur_load = 1'b1;
							hold_v_d = 1'b0;
							state_d  = ST_OPER;
						end
						CMD_END: begin
							q_ready = 1'b1;
							if (lp_q != '0) begin
								err_d = 1'b1;
							end
							state_d = ST_FLUSH;
						end
						default: q_ready = 1'b1;
					endcase
				end
			end
			ST_RPAREN, ST_OPER: begin
				if ((state_q == ST_RPAREN) ? (!stk_empty && !top_is_lp) : pops) begin
					// Pop into the hold slot; the previous hold goes out as not last.
					if (!hold_v_q || can_out) begin
						if (hold_v_q) begin
							out_load   = 1'b1;
							out_d.kind = ELEM_OPERATOR;
							out_d.op   = hold_op_q;
							out_d.err  = err_q;
						end
						hold_v_d  = 1'b1;
						hold_op_d = top;
						cnt_d     = cnt_q - 1'b1;
					end
				end else if (!hold_v_q || can_out) begin
					if (hold_v_q) begin
						out_load   = 1'b1;
						out_d.kind = ELEM_OPERATOR;
						out_d.op   = hold_op_q;
						out_d.err  = err_q;
						out_d.last = 1'b1;
					end
					hold_v_d = 1'b0;
					state_d  = ST_IDLE;
					if (state_q == ST_RPAREN) begin
						if (!stk_empty) begin
							cnt_d = cnt_q - 1'b1;
							lp_d  = lp_q - 1'b1;
						end
					end else if (stk_full) begin
						err_d = 1'b1;
					end else begin
						push_en   = 1'b1;
						push_code = cur_op_q;
						cnt_d     = cnt_q + 1'b1;
					end
				end
			end
			ST_FLUSH: begin
				if (stk_empty) begin
					if (can_out) begin
						out_load   = 1'b1;
						out_d.kind = ELEM_END;
						out_d.err  = err_q;
						out_d.last = 1'b1;
						err_d      = 1'b0;
						state_d    = ST_IDLE;
					end
				end else if (top_is_lp) begin
					cnt_d = cnt_q - 1'b1;
					lp_d  = lp_q - 1'b1;
				end else if (can_out) begin
					out_load   = 1'b1;
					out_d.kind = ELEM_OPERATOR;
					out_d.op   = top;
					out_d.err  = err_q;
					cnt_d      = cnt_q - 1'b1;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			lp_q     <= '0;
			err_q    <= 1'b0;
			hold_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			state_q  <= state_d;
			cnt_q    <= cnt_d;
			lp_q     <= lp_d;
			err_q    <= err_d;
			hold_v_q <= hold_v_d;
			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (m_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		hold_op_q <= hold_op_d;
		if (out_load) begin
			out_q <= out_d;
		end
		if (cur_load) begin
			cur_op_q   <= q_data.op;
			cur_prec_q <= prec_of(q_data.op);
			cur_left_q <= (q_data.op != OP_POW);
		end
		if (push_en) begin
			stk_q[STACK_AW'(cnt_q)] <= push_code;
		end
	end

endmodule

/* hw/rtl/infix_to_postfix_converter.sv */
// Top level of the shunting-yard infix to postfix converter.
// Each input request carries one token (operand, left paren, right paren, operator or end of
// expression); the converter returns the postfix elements that the token releases, with tlast
// on the final element of each token. Tokens pass a registered front stage and a two-entry
// command queue into a stack engine that has a single port on a 32-entry operator stack and
// handles one stack entry per cycle unless the output register stalls. Each token is first
// taken from the queue, and an operand or a left paren needs nothing more. An operator then
// pops each operator that binds tighter, or as tight when it is left-associative, and pushes
// itself; a right paren pops operators down to its left paren and then removes that left
// paren when there is one; end of expression pops every stack entry, dropping left parens,
// then sends the end marker. The end marker carries the error flag of the whole expression
// (unmatched paren or stack overflow) and clears it, so each expression starts clean. Tokens
// of unknown kind and operators with unknown codes are accepted and ignored. A finished element
// waits in the output register while the next token is taken, and the queue lets the front keep
// accepting while the engine stalls on the output side.
module infix_to_postfix_converter import itp_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,   // operator_code[2:0], operand_value[34:3], zeros
	input  logic [KIND_W-1:0]    s_tuser,   // token_kind[2:0]
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,   // element_value[31:0], element_operator[34:32],
	                                        // syntax_error[35], zeros
	output logic [ELEM_W-1:0]    m_tuser,   // element_kind[1:0]
	output logic                 m_tlast    // last_of_run
);

	logic        push_valid, push_ready;
	itp_cmd_t    push_data;
	logic        q_valid, q_ready;
	itp_cmd_t    q_data;
	itp_result_t res;

	itp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	itp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready),
		.pop_data   (q_data)
	);

	itp_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_ready (q_ready),
		.q_data  (q_data),
		.m_valid (m_tvalid),
		.m_ready (m_tready),
		.m_res   (res)
	);

	// Pack the result register onto the stream; unused upper bits stay zero.
	assign m_tdata = {(M_TDATA_W - VALUE_W - OP_W - 1)'(0), res.err, res.op, res.value};
	assign m_tuser = res.kind;
	assign m_tlast = res.last;

endmodule

/* hw/rtl/itp_checker.sv */
// Port-level checks of the converter's result stream, bound to the top level.
module itp_checker import itp_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [M_TDATA_W-1:0] m_tdata,
	input logic [ELEM_W-1:0]    m_tuser,
	input logic                 m_tlast
);

	// A result that is not taken stays as it is.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) &&
		$stable(m_tlast))
		else $error("result changed while stalled");

	// The end marker always closes its token's run.
	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == ELEM_END) |-> m_tlast && (m_tdata[34:0] == '0))
		else $error("end marker malformed");

	// An operand is the only result of its token and carries no operator code.
	a_operand: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == ELEM_OPERAND) |-> m_tlast && (m_tdata[34:32] == '0))
		else $error("operand result malformed");

	// An operator result carries a valid code and no value.
	a_operator: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == ELEM_OPERATOR) |->
		(m_tdata[31:0] == '0) && (m_tdata[34:32] <= OP_POW))
		else $error("operator result malformed");

endmodule

bind infix_to_postfix_converter itp_checker u_itp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
